// File: design/lifn_pkg.sv
// ----------------------------------------------------------------------------
// lifn_pkg
// Types and constants shared by the leaky integrate-and-fire neuron update
// block: request payloads, per-neuron state entry, register indexes.
// ----------------------------------------------------------------------------
package lifn_pkg;

  // input request: one neuron, one time step
  typedef struct packed {
    logic [9:0]         neuron_index;
    logic signed [15:0] syn_current;
  } lifn_in_t;

  // result of one update
  typedef struct packed {
    logic [9:0]         neuron_out;
    logic               fired;
    logic signed [15:0] voltage;
    logic [7:0]         hold_left;
  } lifn_out_t;

  // stored state of one neuron
  typedef struct packed {
    logic signed [15:0] voltage;
    logic [7:0]         count;
  } lifn_entry_t;

  // configuration register indexes
  localparam logic [2:0] REG_REST_LEVEL  = 3'd0;
  localparam logic [2:0] REG_THRESHOLD   = 3'd1;
  localparam logic [2:0] REG_RESET_LEVEL = 3'd2;
  localparam logic [2:0] REG_LEAK_GAIN   = 3'd3;
  localparam logic [2:0] REG_INPUT_GAIN  = 3'd4;
  localparam logic [2:0] REG_BACKGROUND  = 3'd5;
  localparam logic [2:0] REG_REFRACTORY  = 3'd6;

  // register reset values
  localparam logic signed [15:0] REST_LEVEL_RST  = -16'sd16640;
  localparam logic signed [15:0] THRESHOLD_RST   = -16'sd12800;
  localparam logic signed [15:0] RESET_LEVEL_RST = -16'sd16640;
  localparam logic [15:0]        LEAK_GAIN_RST   = 16'd655;
  localparam logic [15:0]        INPUT_GAIN_RST  = 16'd6554;
  localparam logic signed [15:0] BACKGROUND_RST  = 16'sd0;
  localparam logic [7:0]         REFRACTORY_RST  = 8'd20;

  // state of every neuron after reset
  localparam lifn_entry_t ENTRY_RST = '{voltage: -16'sd16640, count: 8'd0};

  // rounding bias for Q.24 to Q8.8 (half toward +infinity)
  localparam logic signed [35:0] ROUND_BIAS = 36'sd32768;

  // saturation bounds in the widened voltage sum
  localparam logic signed [20:0] V_MAX = 21'sd32767;
  localparam logic signed [20:0] V_MIN = -21'sd32768;

endpackage

// File: design/lifn_state_mem.sv
// ----------------------------------------------------------------------------
// lifn_state_mem
// Per-neuron state store: one synchronous memory with a registered read
// port, one write port, and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module lifn_state_mem #(
  parameter int NEURONS = 1024,
  parameter int AW      = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output lifn_pkg::lifn_entry_t rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  lifn_pkg::lifn_entry_t wr_data,
  output logic                 clearing
);

  lifn_pkg::lifn_entry_t mem [NEURONS];
  lifn_pkg::lifn_entry_t rd_data_r;
  logic                  clr_active_r;
  logic [AW-1:0]         clr_addr_r;

  localparam logic [AW-1:0] LAST_ADDR = AW'(NEURONS - 1);

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == LAST_ADDR) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // memory array with registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (clr_active_r) begin
      mem[clr_addr_r] <= lifn_pkg::ENTRY_RST;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_active_r;

endmodule

// File: design/lif_neuron_update.sv
// ----------------------------------------------------------------------------
// lif_neuron_update
// Leaky integrate-and-fire neuron array: each request advances one neuron by
// one forward-Euler time step and returns its spike, voltage and hold count.
//
//   channel  dir  handshake          payload
//   in_      in   in_valid/in_stall    lifn_in_t  (neuron_index, syn_current)
//   out_     out  out_valid/out_stall  lifn_out_t (neuron_out, fired,
//                                                 voltage, hold_left)
//   cfg_     in   cfg_we             cfg_index, cfg_wdata
//
// One request per cycle while the input is not stalled; a request passes the
// state read, the multiply stage and the update into the output register,
// where out_valid rises for its result.
// Two requests for the same neuron are held apart by the read-modify-write
// loop through the state memory: a second request is stalled while the
// first is still in the read or multiply stage, and for longer while a
// stalled output holds the multiply stage.
// After reset the state memory is swept over every neuron entry; no request is
// taken during that sweep, configuration writes are.
// A stalled output holds the pipeline behind it; besides the sweep and the
// same-neuron interlock, the input stalls only when the read stage cannot
// move on.
// ----------------------------------------------------------------------------
module lif_neuron_update #(
  parameter int NEURONS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lifn_pkg::lifn_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lifn_pkg::lifn_out_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

  // configuration registers
  logic signed [15:0] rest_level_r;
  logic signed [15:0] threshold_r;
  logic signed [15:0] reset_level_r;
  logic [15:0]        leak_gain_r;
  logic [15:0]        input_gain_r;
  logic signed [15:0] background_r;
  logic [7:0]         refractory_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_level_r  <= lifn_pkg::REST_LEVEL_RST;
      threshold_r   <= lifn_pkg::THRESHOLD_RST;
      reset_level_r <= lifn_pkg::RESET_LEVEL_RST;
      leak_gain_r   <= lifn_pkg::LEAK_GAIN_RST;
      input_gain_r  <= lifn_pkg::INPUT_GAIN_RST;
      background_r  <= lifn_pkg::BACKGROUND_RST;
      refractory_r  <= lifn_pkg::REFRACTORY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lifn_pkg::REG_REST_LEVEL:  rest_level_r  <= cfg_wdata;
        lifn_pkg::REG_THRESHOLD:   threshold_r   <= cfg_wdata;
        lifn_pkg::REG_RESET_LEVEL: reset_level_r <= cfg_wdata;
        lifn_pkg::REG_LEAK_GAIN:   leak_gain_r   <= cfg_wdata;
        lifn_pkg::REG_INPUT_GAIN:  input_gain_r  <= cfg_wdata;
        lifn_pkg::REG_BACKGROUND:  background_r  <= cfg_wdata;
        lifn_pkg::REG_REFRACTORY:  refractory_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // pipeline registers
  logic               s1_valid_r;
  logic [9:0]         s1_idx_r;
  logic signed [15:0] s1_cur_r;
  logic               s1_oob_r;

  logic               s2_valid_r;
  logic [9:0]         s2_idx_r;
  logic               s2_oob_r;
  logic signed [15:0] s2_v_r;
  logic [7:0]         s2_cnt_r;
  logic signed [33:0] s2_pl_r;
  logic signed [33:0] s2_pi_r;

  logic                out_valid_r;
  lifn_pkg::lifn_out_t out_data_r;

  // flow control
  logic out_free, s2_adv, s2_free, s1_adv, s1_free, in_acc, hazard, clearing;
  logic in_oob;

  assign out_free = !out_valid_r || !out_stall;
  assign s2_adv   = s2_valid_r && out_free;
  assign s2_free  = !s2_valid_r || s2_adv;
  assign s1_adv   = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s1_adv;

  // same neuron still in flight ahead of its writeback
  assign hazard = (s1_valid_r && (s1_idx_r == in_data.neuron_index)) ||
                  (s2_valid_r && (s2_idx_r == in_data.neuron_index));

  assign in_stall = clearing || !s1_free || hazard;
  assign in_acc   = in_valid && !in_stall;
  assign in_oob   = 17'(in_data.neuron_index) >= 17'(NEURONS);

  // state memory
  lifn_pkg::lifn_entry_t rd_entry;
  lifn_pkg::lifn_entry_t wr_entry;
  logic                  wr_en;

  lifn_state_mem #(
    .NEURONS (NEURONS),
    .AW      (AW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc && !in_oob),
    .rd_addr  (AW'(in_data.neuron_index)),
    .rd_data  (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (AW'(s2_idx_r)),
    .wr_data  (wr_entry),
    .clearing (clearing)
  );

  // read stage: differences and the two products
  logic signed [16:0] diff_leak;
  logic signed [16:0] sum_cur;
  logic signed [33:0] prod_leak;
  logic signed [33:0] prod_in;

  assign diff_leak = 17'(rest_level_r) - 17'(rd_entry.voltage);
  assign sum_cur   = 17'(s1_cur_r) + 17'(background_r);
  assign prod_leak = $signed({1'b0, leak_gain_r}) * diff_leak;
  assign prod_in   = $signed({1'b0, input_gain_r}) * sum_cur;

  // update stage: round, saturate, threshold
  logic signed [35:0] acc_sum;
  logic signed [19:0] dv;
  logic signed [20:0] nv;
  logic signed [15:0] v_int;
  logic               fire;
  lifn_pkg::lifn_out_t res;

  assign acc_sum = 36'(s2_pl_r) + 36'(s2_pi_r) + lifn_pkg::ROUND_BIAS;
  assign dv      = acc_sum[35:16];
  assign nv      = 21'(s2_v_r) + 21'(dv);

  always_comb begin
    if (nv > lifn_pkg::V_MAX) begin
      v_int = 16'sh7FFF;
    end else if (nv < lifn_pkg::V_MIN) begin
      v_int = -16'sh8000;
    end else begin
      v_int = nv[15:0];
    end
  end

  assign fire = v_int >= threshold_r;

  always_comb begin
    res.neuron_out = s2_idx_r;
    if (s2_oob_r) begin
      res.fired     = 1'b0;
      res.voltage   = '0;
      res.hold_left = '0;
    end else if (s2_cnt_r != 8'd0) begin
      res.fired     = 1'b0;
      res.voltage   = s2_v_r;
      res.hold_left = s2_cnt_r - 8'd1;
    end else if (fire) begin
      res.fired     = 1'b1;
      res.voltage   = reset_level_r;
      res.hold_left = refractory_r;
    end else begin
      res.fired     = 1'b0;
      res.voltage   = v_int;
      res.hold_left = '0;
    end
  end

  // writeback as the result moves into the output register
  assign wr_en            = s2_adv && !s2_oob_r;
  assign wr_entry.voltage = res.voltage;
  assign wr_entry.count   = res.hold_left;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= in_acc;
      end
      if (s2_free) begin
        s2_valid_r <= s1_adv;
      end
      if (out_free) begin
        out_valid_r <= s2_adv;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_idx_r <= in_data.neuron_index;
      s1_cur_r <= in_data.syn_current;
      s1_oob_r <= in_oob;
    end
    if (s1_adv) begin
      s2_idx_r <= s1_idx_r;
      s2_oob_r <= s1_oob_r;
      s2_v_r   <= rd_entry.voltage;
      s2_cnt_r <= rd_entry.count;
      s2_pl_r  <= prod_leak;
      s2_pi_r  <= prod_in;
    end
    if (s2_adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // no request taken during the clearing sweep
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !clearing)
    else $error("request accepted during clearing sweep");

  // two in-flight requests never target the same neuron
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_valid_r && !s1_oob_r && !s2_oob_r) |-> (s1_idx_r != s2_idx_r))
    else $error("read-modify-write overlap on one neuron");

  // a spike reloads the hold count and the reset voltage
  a_fire_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.fired) |->
      (out_data_r.hold_left == refractory_r && out_data_r.voltage == reset_level_r))
    else $error("spike result without reload values");

  // a result leaving the update stage lands in the output register
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s2_adv |=> out_valid_r)
    else $error("update stage result lost");

endmodule
